/* rtl/md5_block_hash_unit_defines.svh */
// Assertion macros for the MD5 block hash unit.
`ifndef MD5_BLOCK_HASH_UNIT_DEFINES_SVH
`define MD5_BLOCK_HASH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MD5_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/md5_pkg.sv */
package md5_pkg;

    typedef struct packed {
        logic [31:0] d;
        logic [31:0] c;
        logic [31:0] b;
        logic [31:0] a;
    } md5_words_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [3:0] LAST_WORD = 4'd15;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;
    localparam logic [1:0] GRP_I = 2'd3;

    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Message word index for a round.
    function automatic logic [3:0] md5_g(input logic [5:0] idx);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = idx[3:0];
        case (idx[5:4])
            GRP_F:   g = i4;
            GRP_G:   g = 4'((i4 << 2) + i4 + 4'd1);
            GRP_H:   g = 4'((i4 << 1) + i4 + 4'd5);
            default: g = 4'((i4 << 3) - i4);
        endcase
        return g;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
            4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;
            4'd14: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

/* rtl/md5_round.sv */
module md5_round
    import md5_pkg::*;
(
    input  md5_words_t  cur,
    input  logic [31:0] km,
    input  logic [5:0]  rnd,
    output md5_words_t  nxt
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_wide;

    always_comb
    begin
        case (rnd[5:4])
            GRP_F:   f = (cur.b & cur.c) | (~cur.b & cur.d);
            GRP_G:   f = (cur.d & cur.b) | (~cur.d & cur.c);
            GRP_H:   f = cur.b ^ cur.c ^ cur.d;
            default: f = cur.c ^ (cur.b | ~cur.d);
        endcase
    end

    assign sum      = cur.a + f + km;
    assign rot_wide = {sum, sum} << md5_rot(rnd);

    assign nxt.a = cur.d;
    assign nxt.b = cur.b + rot_wide[63:32];
    assign nxt.c = cur.b;
    assign nxt.d = cur.c;

endmodule

/* rtl/md5_block_hash_unit.sv */
// MD5 compression engine. Padded message words (little-endian, sixteen per
// 512-bit block) are taken one per cycle on the msg channel while msg_stall
// is low; start_message on a word reloads the initial vector and restarts the
// block, end_message marks the final block. After the sixteenth word the unit
// runs one MD5 round per cycle through a single round datapath: a set-up
// state (PREP), rounds 0 to 63 and a fold state (FOLD), with msg_stall high
// throughout. The digest (A,B in digest_low, C,D in digest_high) sits in an
// output register until taken; the fold of a later final block waits while
// an earlier digest is still held.
`include "md5_block_hash_unit_defines.svh"

module md5_block_hash_unit
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [31:0] msg_word,
    input  logic        start_message,
    input  logic        end_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PREP  = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_FOLD  = 4'b1000
    } state_t;

    localparam md5_words_t IV = '{d: IV_D, c: IV_C, b: IV_B, a: IV_A};

    state_t      state_reg, state_next;
    logic [3:0]  word_index_reg, word_index_next;
    logic        final_pending_reg, final_pending_next;
    logic [5:0]  rnd_reg, rnd_next;
    md5_words_t  chain_reg, chain_next;
    md5_words_t  work_reg, work_next;
    logic        digest_valid_reg, digest_valid_next;
    logic [31:0] km_reg;
    logic [63:0] digest_low_reg, digest_high_reg;
    logic [31:0] buf_mem [16];

    logic        msg_acc;
    logic [3:0]  wr_addr;
    logic        km_load;
    logic [5:0]  km_idx;
    logic        fold_go;
    md5_words_t  round_out;
    md5_words_t  chain_sum;

    assign msg_stall = (state_reg != ST_IDLE);
    assign msg_acc   = msg_valid && !msg_stall;
    assign wr_addr   = start_message ? 4'd0 : word_index_reg;

    assign km_load = (state_reg == ST_PREP) || (state_reg == ST_ROUND);
    assign km_idx  = (state_reg == ST_PREP) ? 6'd0 : 6'(rnd_reg + 6'd1);

    assign chain_sum.a = chain_reg.a + work_reg.a;
    assign chain_sum.b = chain_reg.b + work_reg.b;
    assign chain_sum.c = chain_reg.c + work_reg.c;
    assign chain_sum.d = chain_reg.d + work_reg.d;

    assign fold_go = (state_reg == ST_FOLD)
                     && (!final_pending_reg || !digest_valid_reg || !digest_stall);

    md5_round u_round (
        .cur (work_reg),
        .km  (km_reg),
        .rnd (rnd_reg),
        .nxt (round_out)
    );

    always_comb
    begin
        state_next         = state_reg;
        word_index_next    = word_index_reg;
        final_pending_next = final_pending_reg;
        rnd_next           = rnd_reg;
        chain_next         = chain_reg;
        work_next          = work_reg;
        digest_valid_next  = digest_valid_reg;

        if (digest_valid_reg && !digest_stall)
        begin
            digest_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_acc)
                begin
                    if (start_message)
                    begin
                        chain_next         = IV;
                        final_pending_next = end_message;
                    end
                    else
                    begin
                        final_pending_next = final_pending_reg | end_message;
                    end
                    word_index_next = 4'(wr_addr + 4'd1);
                    if (wr_addr == LAST_WORD)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                work_next  = chain_reg;
                rnd_next   = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                work_next = round_out;
                rnd_next  = 6'(rnd_reg + 6'd1);
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (fold_go)
                begin
                    chain_next = chain_sum;
                    if (final_pending_reg)
                    begin
                        digest_valid_next  = 1'b1;
                        final_pending_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            word_index_reg    <= 4'd0;
            final_pending_reg <= 1'b0;
            rnd_reg           <= 6'd0;
            chain_reg         <= IV;
            work_reg          <= '0;
            digest_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            word_index_reg    <= word_index_next;
            final_pending_reg <= final_pending_next;
            rnd_reg           <= rnd_next;
            chain_reg         <= chain_next;
            work_reg          <= work_next;
            digest_valid_reg  <= digest_valid_next;
        end
    end

    // Word buffer, K + M prefetch for the next round and digest output registers.
    always_ff @(posedge clk)
    begin
        if (msg_acc)
        begin
            buf_mem[wr_addr] <= msg_word;
        end
        if (km_load)
        begin
            km_reg <= md5_k(km_idx) + buf_mem[md5_g(km_idx)];
        end
        if (fold_go && final_pending_reg)
        begin
            digest_low_reg  <= {chain_sum.b, chain_sum.a};
            digest_high_reg <= {chain_sum.d, chain_sum.c};
        end
    end

    assign digest_valid = digest_valid_reg;
    assign digest_low   = digest_low_reg;
    assign digest_high  = digest_high_reg;

    `MD5_ASSERT_NEXT(a_last_word_starts, msg_acc && (wr_addr == LAST_WORD), state_reg == ST_PREP, "sixteenth beat did not start compression")
    `MD5_ASSERT_NEXT(a_rounds_end, (state_reg == ST_ROUND) && (rnd_reg == LAST_ROUND), state_reg == ST_FOLD, "round 63 not followed by fold")
    `MD5_ASSERT_IMPLY(a_digest_from_fold, $rose(digest_valid_reg), $past(state_reg) == ST_FOLD, "digest raised outside fold")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int TOTAL_BEATS = 1920;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD = 600;
    localparam int DIRECTED_ROWS = 19;

    localparam int MSG_CLEAN = 0;
    localparam int MSG_CHAINED = 1;
    localparam int MSG_ABANDONED = 2;
    localparam int MSG_NOISE = 3;

    localparam int STALL_NONE = 0;
    localparam int STALL_COIN = 1;
    localparam int STALL_HEAVY = 2;
    localparam int STALL_BLIP = 3;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [0:63][31:0] SINE_K = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [0:15][4:0] ROT_AMT = {
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } digest_t;

    typedef struct packed {
        logic [31:0] word;
        bit          st;
        bit          en;
        bit          known;
        logic [63:0] lo;
        logic [63:0] hi;
    } plan_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_stall;
    logic [31:0] msg_word = 32'h0;
    logic        start_message = 1'b0;
    logic        end_message = 1'b0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    logic [31:0] blk_words [16];
    logic [31:0] chain_val [4];
    logic [3:0]  blk_idx;
    bit          end_seen;

    digest_t     digest_q [$];
    plan_row_t   plan [DIRECTED_ROWS];

    int          beats_sent = 0;
    int          digests_seen = 0;
    int          messages_sent = 0;
    int          errors = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    md5_block_hash_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg_word     (msg_word),
        .start_message(start_message),
        .end_message  (end_message),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_low   (digest_low),
        .digest_high  (digest_high)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic plan_row_t row(input logic [31:0] w, input bit st, input bit en,
                                      input bit known, input logic [63:0] lo,
                                      input logic [63:0] hi);
        plan_row_t r;
        r.word = w;
        r.st = st;
        r.en = en;
        r.known = known;
        r.lo = lo;
        r.hi = hi;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0: w = 32'h0;
            1: w = 32'hffffffff;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic predict_digest(input logic [31:0] w, input bit st, input bit en,
                                  output bit emitted, output digest_t dg);
        logic [31:0] a, b, c, d, f, sum, tmp;
        int          g, grp, s;
        emitted = 1'b0;
        dg = '0;
        if (st)
        begin
            chain_val[0] = INIT_A;
            chain_val[1] = INIT_B;
            chain_val[2] = INIT_C;
            chain_val[3] = INIT_D;
            blk_idx = 4'd0;
            end_seen = 1'b0;
        end
        blk_words[blk_idx] = w;
        if (en)
            end_seen = 1'b1;
        blk_idx = blk_idx + 4'd1;
        if (blk_idx == 4'd0)
        begin
            a = chain_val[0];
            b = chain_val[1];
            c = chain_val[2];
            d = chain_val[3];
            for (int i = 0; i < 64; i++)
            begin
                grp = i / 16;
                case (grp)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1:
                    begin
                        f = (d & b) | (~d & c);
                        g = 5 * i + 1;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = 3 * i + 5;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = 7 * i;
                    end
                endcase
                sum = a + f + SINE_K[i] + blk_words[g % 16];
                s = ROT_AMT[grp * 4 + i % 4];
                tmp = d;
                d = c;
                c = b;
                b = b + ((sum << s) | (sum >> (32 - s)));
                a = tmp;
            end
            chain_val[0] = chain_val[0] + a;
            chain_val[1] = chain_val[1] + b;
            chain_val[2] = chain_val[2] + c;
            chain_val[3] = chain_val[3] + d;
            if (end_seen)
            begin
                end_seen = 1'b0;
                emitted = 1'b1;
                dg.lo = {chain_val[1], chain_val[0]};
                dg.hi = {chain_val[3], chain_val[2]};
            end
        end
    endtask

    task automatic send_beat(input logic [31:0] w, input bit st, input bit en,
                             input bit known, input logic [63:0] lo, input logic [63:0] hi);
        int      gap;
        bit      emitted;
        digest_t dg;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                msg_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        msg_valid <= 1'b1;
        msg_word <= w;
        start_message <= st;
        end_message <= en;
        do
            @(posedge clk);
        while (msg_stall);
        beats_sent++;
        predict_digest(w, st, en, emitted, dg);
        if (emitted)
        begin
            if (known)
            begin
                dg.lo = lo;
                dg.hi = hi;
            end
            digest_q.push_back(dg);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        msg_valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver back-pressure
    initial
    begin
        int mode, left, hold;
        mode = STALL_NONE;
        left = 0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                digest_stall <= 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(STALL_NONE, STALL_BLIP);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    STALL_NONE:  digest_stall <= 1'b0;
                    STALL_COIN:  digest_stall <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: digest_stall <= (left % 4) != 0;
                    default:     digest_stall <= (left % 9) < 2;
                endcase
            end
        end
    end

    // digest checker and watchdog
    initial
    begin
        int      idle_cycles;
        digest_t want;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((msg_valid && !msg_stall) || (digest_valid && !digest_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (rst_n && digest_valid && !digest_stall)
            begin
                digests_seen++;
                if (digest_q.size() == 0)
                begin
                    $error("unexpected digest beat: low %h high %h", digest_low, digest_high);
                    errors++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (digest_low !== want.lo)
                    begin
                        $error("digest_low: expected %h, got %h", want.lo, digest_low);
                        errors++;
                    end
                    if (digest_high !== want.hi)
                    begin
                        $error("digest_high: expected %h, got %h", want.hi, digest_high);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int kind, nblk, end_at, len;
        bit st, en, hold_done, paused;
        hold_done = 1'b0;
        paused = 1'b0;
        chain_val[0] = INIT_A;
        chain_val[1] = INIT_B;
        chain_val[2] = INIT_C;
        chain_val[3] = INIT_D;
        blk_idx = 4'd0;
        end_seen = 1'b0;
        for (int i = 0; i < 16; i++)
            blk_words[i] = 32'h0;

        // stray start with end flag, dropped by a start mid-block;
        // then the padded empty message with end on a non-final word
        plan[0]  = row(32'hffffffff, 1, 1, 0, 64'h0, 64'h0);
        plan[1]  = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[2]  = row(32'haaaaaaaa, 0, 0, 0, 64'h0, 64'h0);
        plan[3]  = row(32'h00000080, 1, 0, 0, 64'h0, 64'h0);
        plan[4]  = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[5]  = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[6]  = row(32'h00000000, 0, 1, 0, 64'h0, 64'h0);
        plan[7]  = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[8]  = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[9]  = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[10] = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[11] = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[12] = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[13] = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[14] = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[15] = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[16] = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[17] = row(32'h00000000, 0, 0, 0, 64'h0, 64'h0);
        plan[18] = row(32'h00000000, 0, 0, 1, 64'h04b2008fd98c1dd4, 64'h7e42f8ec980980e9);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_beat(plan[i].word, plan[i].st, plan[i].en, plan[i].known,
                      plan[i].lo, plan[i].hi);

        while (beats_sent < TOTAL_BEATS)
        begin
            len = $urandom_range(0, 99);
            kind = (len < 70) ? MSG_CLEAN : (len < 80) ? MSG_CHAINED :
                   (len < 90) ? MSG_ABANDONED : MSG_NOISE;
            case (kind)
                MSG_CLEAN, MSG_CHAINED:
                begin
                    nblk = $urandom_range(1, 3);
                    end_at = $urandom_range(0, 15);
                    for (int blk = 0; blk < nblk; blk++)
                        for (int w = 0; w < 16; w++)
                        begin
                            st = (kind == MSG_CLEAN) && (blk == 0) && (w == 0);
                            en = (blk == nblk - 1) &&
                                 ((w == end_at) || ($urandom_range(0, 15) == 0));
                            send_beat(rand_word(), st, en, 0, 64'h0, 64'h0);
                        end
                end
                MSG_ABANDONED:
                begin
                    len = $urandom_range(1, 15);
                    for (int w = 0; w < len; w++)
                        send_beat(rand_word(), w == 0, $urandom_range(0, 7) == 0,
                                  0, 64'h0, 64'h0);
                end
                default:
                begin
                    len = $urandom_range(1, 20);
                    for (int w = 0; w < len; w++)
                        send_beat(rand_word(), $urandom_range(0, 7) == 0,
                                  $urandom_range(0, 5) == 0, 0, 64'h0, 64'h0);
                end
            endcase
            messages_sent++;
            if (!hold_done && beats_sent >= 400)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!paused && beats_sent >= 1100)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (100) @(posedge clk);
        $display("run covered %0d message words in %0d random messages plus the directed table",
                 beats_sent, messages_sent);
        $display("%0d digests checked, with restarts, chaining and output back-pressure",
                 digests_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/md5_pkg.sv
rtl/md5_round.sv
rtl/md5_block_hash_unit.sv
tb/testbench.sv
